/* design/plclip_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package plclip_pkg;

	localparam int CoordWidth   = 32;
	localparam int FracBits     = 16;
	localparam int IntWidth     = CoordWidth + 4;
	localparam int ScaleWidth   = 31;
	localparam int MulBWidth    = (IntWidth > ScaleWidth) ? IntWidth : ScaleWidth;
	localparam int ProdWidth    = IntWidth + MulBWidth;
	localparam int OrgWidth     = 12;
	localparam int PixWidth     = 16;
	localparam int CfgAddrWidth = 3;
	localparam int CfgDataWidth = 32;
	localparam int InQueueDepth  = 2;
	localparam int OutQueueDepth = 2;

	localparam logic [40:0] OfsCap = 41'd1 << 40;

	localparam logic [CfgAddrWidth-1:0] RegMinX    = 3'd0;
	localparam logic [CfgAddrWidth-1:0] RegMaxX    = 3'd1;
	localparam logic [CfgAddrWidth-1:0] RegMinY    = 3'd2;
	localparam logic [CfgAddrWidth-1:0] RegMaxY    = 3'd3;
	localparam logic [CfgAddrWidth-1:0] RegXOrigin = 3'd4;
	localparam logic [CfgAddrWidth-1:0] RegYOrigin = 3'd5;
	localparam logic [CfgAddrWidth-1:0] RegXScale  = 3'd6;
	localparam logic [CfgAddrWidth-1:0] RegYScale  = 3'd7;

	localparam logic CmdMove = 1'b0;
	localparam logic CmdLine = 1'b1;

	typedef struct packed {
		logic signed [CoordWidth-1:0] sample_x;
		logic signed [CoordWidth-1:0] sample_y;
		logic                         first_point;
	} sample_t;

	typedef struct packed {
		logic                       command;
		logic signed [PixWidth-1:0] pixel_x;
		logic signed [PixWidth-1:0] pixel_y;
		logic                       last;
	} result_t;

	typedef struct packed {
		logic signed [CoordWidth-1:0] min_x;
		logic signed [CoordWidth-1:0] max_x;
		logic signed [CoordWidth-1:0] min_y;
		logic signed [CoordWidth-1:0] max_y;
		logic [OrgWidth-1:0]          x_origin;
		logic [OrgWidth-1:0]          y_origin;
		logic [ScaleWidth-1:0]        x_scale;
		logic [ScaleWidth-1:0]        y_scale;
	} cfg_t;

	typedef struct packed {
		logic below;
		logic above;
		logic left;
		logic right;
	} outcode_t;

	typedef struct packed {
		sample_t  s;
		outcode_t oc;
	} item_t;

	typedef struct packed {
		logic start;
		logic divide;
	} md_req_t;

endpackage

`default_nettype wire

/* design/plclip_fifo.sv */
`timescale 1ns / 1ps
`default_nettype none

module plclip_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_en,
	input  wire logic [WIDTH-1:0] wr_data,
	output logic                  full,
	input  wire logic             rd_en,
	output logic [WIDTH-1:0]      rd_data,
	output logic                  empty
);
	localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNTW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTRW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNTW-1:0]  cnt_q;
	logic             do_wr, do_rd;

	assign full    = (cnt_q == CNTW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTRW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTRW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

`default_nettype wire

/* design/plclip_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module plclip_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire plclip_pkg::cfg_t  cfg,
	input  wire logic              push,
	input  wire plclip_pkg::sample_t sample,
	output logic                   full,
	input  wire logic              pop,
	output plclip_pkg::item_t      item,
	output logic                   valid
);
	import plclip_pkg::*;

	item_t in_item;
	logic  q_empty;

	// classify the new endpoint against the window
	always_comb begin
		in_item.s        = sample;
		in_item.oc.below = sample.sample_y < cfg.min_y;
		in_item.oc.above = sample.sample_y > cfg.max_y;
		in_item.oc.left  = sample.sample_x < cfg.min_x;
		in_item.oc.right = sample.sample_x > cfg.max_x;
	end

	plclip_fifo #(
		.WIDTH($bits(item_t)),
		.DEPTH(InQueueDepth)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (push),
		.wr_data(in_item),
		.full   (full),
		.rd_en  (pop),
		.rd_data(item),
		.empty  (q_empty)
	);

	assign valid = !q_empty;

endmodule

`default_nettype wire

/* design/plclip_muldiv.sv */
`timescale 1ns / 1ps
`default_nettype none

module plclip_muldiv (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire plclip_pkg::md_req_t               req,
	input  wire logic [plclip_pkg::IntWidth-1:0]   a,
	input  wire logic [plclip_pkg::MulBWidth-1:0]  b,
	input  wire logic [plclip_pkg::IntWidth-1:0]   dn,
	output logic                                   done,
	output logic [plclip_pkg::ProdWidth-1:0]       res
);
	import plclip_pkg::*;

	localparam int W    = IntWidth;
	localparam int MB   = MulBWidth;
	localparam int PW   = ProdWidth;
	localparam int K    = 16;
	localparam int NCH  = (MB + K - 1) / K;
	localparam int BPAD = NCH * K;
	localparam int CNTW = $clog2(W + 1);

	localparam logic [2:0] U_IDLE = 3'd0;
	localparam logic [2:0] U_MUL  = 3'd1;
	localparam logic [2:0] U_DLD  = 3'd2;
	localparam logic [2:0] U_DIV  = 3'd3;
	localparam logic [2:0] U_END  = 3'd4;

	logic [2:0]      state_q;
	logic [CNTW-1:0] cnt_q;
	logic [W-1:0]    a_q, dx_q, dn_q, rem_q;
	logic [BPAD-1:0] b_q;
	logic            div_q;
	logic [PW-1:0]   acc_q;
	logic [2*W-1:0]  dvd_q, quo_q;

	logic [K-1:0]    chunk;
	logic [W+K-1:0]  mulp;
	logic [W:0]      t0, t1;
	logic [W-1:0]    r1, r2;
	logic            qb0, qb1;
	logic            over;
	logic [W-1:0]    qlo, qsat;

	assign chunk = b_q[BPAD-1 -: K];
	assign mulp  = a_q * chunk;

	// two restoring steps per cycle
	always_comb begin
		t0 = {rem_q, dvd_q[2*W-1]};
		if (t0 >= {1'b0, dn_q}) begin
			r1  = t0[W-1:0] - dn_q;
			qb0 = 1'b1;
		end else begin
			r1  = t0[W-1:0];
			qb0 = 1'b0;
		end
		t1 = {r1, dvd_q[2*W-2]};
		if (t1 >= {1'b0, dn_q}) begin
			r2  = t1[W-1:0] - dn_q;
			qb1 = 1'b1;
		end else begin
			r2  = t1[W-1:0];
			qb1 = 1'b0;
		end
	end

	assign over = |quo_q[2*W-1:W];
	assign qlo  = quo_q[W-1:0];
	assign qsat = (over || (qlo > dx_q)) ? dx_q : qlo;
	assign done = (state_q == U_END);
	assign res  = div_q ? PW'(qsat) : acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= U_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				U_IDLE: begin
					if (req.start) begin
						state_q <= U_MUL;
						cnt_q   <= CNTW'(NCH);
					end
				end
				U_MUL: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CNTW'(1)) begin
						state_q <= div_q ? U_DLD : U_END;
					end
				end
				U_DLD: begin
					state_q <= U_DIV;
					cnt_q   <= CNTW'(W);
				end
				U_DIV: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CNTW'(1)) begin
						state_q <= U_END;
					end
				end
				U_END: begin
					state_q <= U_IDLE;
				end
				default: begin
					state_q <= U_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			U_IDLE: begin
				if (req.start) begin
					a_q   <= a;
					b_q   <= BPAD'(b);
					dx_q  <= b[W-1:0];
					dn_q  <= dn;
					div_q <= req.divide;
					acc_q <= '0;
				end
			end
			U_MUL: begin
				acc_q <= {acc_q[PW-K-1:0], {K{1'b0}}} + {{(PW-W-K){1'b0}}, mulp};
				b_q   <= b_q << K;
			end
			U_DLD: begin
				dvd_q <= acc_q[2*W-1:0];
				rem_q <= '0;
				quo_q <= '0;
			end
			U_DIV: begin
				dvd_q <= dvd_q << 2;
				rem_q <= r2;
				quo_q <= {quo_q[2*W-3:0], qb0, qb1};
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

/* design/plclip_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module plclip_back #(
	parameter int FRAC_BITS = plclip_pkg::FracBits
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire plclip_pkg::cfg_t    cfg,
	input  wire plclip_pkg::item_t   item,
	input  wire logic                in_valid,
	output logic                     in_pop,
	output logic                     out_push,
	output plclip_pkg::result_t      out_item,
	input  wire logic                out_full
);
	import plclip_pkg::*;

	localparam int W  = IntWidth;
	localparam int CW = CoordWidth;
	localparam int PW = ProdWidth;

	localparam logic [3:0] B_IDLE = 4'd0;
	localparam logic [3:0] B_SY   = 4'd1;
	localparam logic [3:0] B_SX   = 4'd2;
	localparam logic [3:0] B_EY   = 4'd3;
	localparam logic [3:0] B_EX   = 4'd4;
	localparam logic [3:0] B_IP   = 4'd5;
	localparam logic [3:0] B_IW   = 4'd6;
	localparam logic [3:0] B_PX   = 4'd7;
	localparam logic [3:0] B_PXW  = 4'd8;
	localparam logic [3:0] B_PY   = 4'd9;
	localparam logic [3:0] B_PYW  = 4'd10;
	localparam logic [3:0] B_WM   = 4'd11;
	localparam logic [3:0] B_WL   = 4'd12;

	localparam logic [1:0] PH_SY = 2'd0;
	localparam logic [1:0] PH_SX = 2'd1;
	localparam logic [1:0] PH_EY = 2'd2;
	localparam logic [1:0] PH_EX = 2'd3;

	function automatic logic signed [W-1:0] ext(input logic signed [CW-1:0] v);
		ext = {{(W-CW){v[CW-1]}}, v};
	endfunction

	function automatic logic [W-1:0] absdiff(input logic signed [W-1:0] p,
		input logic signed [W-1:0] q);
		logic signed [W:0] d;
		d = {p[W-1], p} - {q[W-1], q};
		absdiff = d[W] ? W'(-d) : d[W-1:0];
	endfunction

	function automatic logic [PixWidth-1:0] to_pix(input logic [PW-1:0] prod,
		input logic neg, input logic [OrgWidth-1:0] org);
		logic [PW-1:0]      sh;
		logic [40:0]        off;
		logic signed [42:0] p;
		sh  = prod >> (2 * FRAC_BITS);
		off = (sh > PW'(OfsCap)) ? OfsCap : sh[40:0];
		p   = neg ? $signed({31'd0, org}) - $signed({2'd0, off})
		          : $signed({31'd0, org}) + $signed({2'd0, off});
		if (p > 43'sd32767) begin
			to_pix = 16'h7fff;
		end else if (p < -43'sd32768) begin
			to_pix = 16'h8000;
		end else begin
			to_pix = p[PixWidth-1:0];
		end
	endfunction

	logic [3:0]                   state_q;
	logic [1:0]                   phase_q;
	logic                         pend_q, mv_vld_q, line_vis_q, kind_q;
	logic signed [CW-1:0]         prev_x_q, prev_y_q;
	logic signed [W-1:0]          xa_q, ya_q, xb_q, yb_q, e_q;
	outcode_t                     oc_q;
	logic [PixWidth-1:0]          px_q, mv_x_q, mv_y_q, ln_y_q;

	logic signed [W-1:0] mnx, mxx, mny, mxy;
	logic signed [W-1:0] ia, ib, ic, id, ires;
	logic [W-1:0]        n_mag, dn_mag, dx_mag, qv;
	logic                ineg;
	logic signed [W-1:0] pvx, pvy;
	logic [W-1:0]        magx, magy;
	logic                negx, negy;

	md_req_t               md_req;
	logic [W-1:0]          md_a, md_dn;
	logic [MulBWidth-1:0]  md_b;
	logic                  md_done;
	logic [PW-1:0]         md_res;

	assign mnx = ext(cfg.min_x);
	assign mxx = ext(cfg.max_x);
	assign mny = ext(cfg.min_y);
	assign mxy = ext(cfg.max_y);

	always_comb begin
		case (phase_q)
			PH_SY:   begin ia = xa_q; ib = xb_q; ic = ya_q; id = yb_q; end
			PH_SX:   begin ia = ya_q; ib = yb_q; ic = xa_q; id = xb_q; end
			PH_EY:   begin ia = xb_q; ib = xa_q; ic = yb_q; id = ya_q; end
			default: begin ia = yb_q; ib = ya_q; ic = xb_q; id = xa_q; end
		endcase
		n_mag  = absdiff(e_q, ic);
		dn_mag = absdiff(id, ic);
		dx_mag = absdiff(ib, ia);
		ineg   = (e_q < ic) ^ (id < ic) ^ (ib < ia);
		qv     = md_res[W-1:0];
		ires   = ineg ? $signed(ia - qv) : $signed(ia + qv);
	end

	assign pvx  = kind_q ? xb_q : xa_q;
	assign pvy  = kind_q ? yb_q : ya_q;
	assign magx = absdiff(pvx, mnx);
	assign magy = absdiff(pvy, mny);
	assign negx = pvx < mnx;
	assign negy = !(pvy < mny);

	always_comb begin
		md_req.start  = 1'b0;
		md_req.divide = 1'b0;
		md_a          = n_mag;
		md_b          = MulBWidth'(dx_mag);
		md_dn         = dn_mag;
		case (state_q)
			B_IP: begin
				md_req.start  = (dn_mag != '0);
				md_req.divide = 1'b1;
			end
			B_PX: begin
				md_req.start = 1'b1;
				md_a         = magx;
				md_b         = MulBWidth'(cfg.x_scale);
			end
			B_PY: begin
				md_req.start = 1'b1;
				md_a         = magy;
				md_b         = MulBWidth'(cfg.y_scale);
			end
			default: begin
			end
		endcase
	end

	plclip_muldiv u_muldiv (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (md_req),
		.a     (md_a),
		.b     (md_b),
		.dn    (md_dn),
		.done  (md_done),
		.res   (md_res)
	);

	assign in_pop = (state_q == B_IDLE) && in_valid;

	always_comb begin
		out_push         = 1'b0;
		out_item.command = CmdLine;
		out_item.pixel_x = px_q;
		out_item.pixel_y = ln_y_q;
		out_item.last    = 1'b1;
		if (state_q == B_WM) begin
			out_push         = mv_vld_q && !out_full;
			out_item.command = CmdMove;
			out_item.pixel_x = mv_x_q;
			out_item.pixel_y = mv_y_q;
			out_item.last    = !line_vis_q;
		end else if (state_q == B_WL) begin
			out_push = line_vis_q && !out_full;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= B_IDLE;
			phase_q    <= PH_SY;
			pend_q     <= 1'b1;
			mv_vld_q   <= 1'b0;
			line_vis_q <= 1'b0;
			kind_q     <= 1'b0;
			prev_x_q   <= '0;
			prev_y_q   <= '0;
		end else begin
			unique case (state_q)
				B_IDLE: begin
					if (in_valid) begin
						prev_x_q   <= item.s.sample_x;
						prev_y_q   <= item.s.sample_y;
						mv_vld_q   <= 1'b0;
						line_vis_q <= 1'b0;
						if (item.s.first_point) begin
							pend_q <= 1'b1;
						end else if (pend_q) begin
							state_q <= B_SY;
						end else begin
							state_q <= B_EY;
						end
					end
				end
				B_SY: begin
					if (ya_q < mny) begin
						phase_q <= PH_SY;
						state_q <= oc_q.below ? B_IDLE : B_IP;
					end else if (ya_q > mxy) begin
						phase_q <= PH_SY;
						state_q <= oc_q.above ? B_IDLE : B_IP;
					end else begin
						state_q <= B_SX;
					end
				end
				B_SX: begin
					if (xa_q < mnx) begin
						phase_q <= PH_SX;
						state_q <= oc_q.left ? B_IDLE : B_IP;
					end else if (xa_q > mxx) begin
						phase_q <= PH_SX;
						state_q <= oc_q.right ? B_IDLE : B_IP;
					end else begin
						kind_q  <= 1'b0;
						state_q <= B_PX;
					end
				end
				B_EY: begin
					if (oc_q.below) begin
						pend_q  <= 1'b1;
						phase_q <= PH_EY;
						state_q <= (ya_q < mny) ? B_WM : B_IP;
					end else if (oc_q.above) begin
						pend_q  <= 1'b1;
						phase_q <= PH_EY;
						state_q <= (ya_q > mxy) ? B_WM : B_IP;
					end else begin
						state_q <= B_EX;
					end
				end
				B_EX: begin
					if (xb_q < mnx) begin
						pend_q  <= 1'b1;
						phase_q <= PH_EX;
						state_q <= (xa_q < mnx) ? B_WM : B_IP;
					end else if (xb_q > mxx) begin
						pend_q  <= 1'b1;
						phase_q <= PH_EX;
						state_q <= (xa_q > mxx) ? B_WM : B_IP;
					end else begin
						kind_q  <= 1'b1;
						state_q <= B_PX;
					end
				end
				B_IP, B_IW: begin
					if ((state_q == B_IP && dn_mag == '0) || (state_q == B_IW && md_done)) begin
						unique case (phase_q)
							PH_SY: state_q <= B_SX;
							PH_SX: begin kind_q <= 1'b0; state_q <= B_PX; end
							PH_EY: state_q <= B_EX;
							default: begin kind_q <= 1'b1; state_q <= B_PX; end
						endcase
					end else begin
						state_q <= B_IW;
					end
				end
				B_PX: begin
					state_q <= B_PXW;
				end
				B_PXW: begin
					if (md_done) begin
						state_q <= B_PY;
					end
				end
				B_PY: begin
					state_q <= B_PYW;
				end
				B_PYW: begin
					if (md_done) begin
						if (kind_q) begin
							line_vis_q <= 1'b1;
							state_q    <= B_WM;
						end else begin
							mv_vld_q <= 1'b1;
							pend_q   <= 1'b0;
							state_q  <= B_EY;
						end
					end
				end
				B_WM: begin
					if (!mv_vld_q || !out_full) begin
						state_q <= B_WL;
					end
				end
				B_WL: begin
					if (!line_vis_q || !out_full) begin
						state_q <= B_IDLE;
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == B_IDLE && in_valid) begin
			xa_q <= ext(prev_x_q);
			ya_q <= ext(prev_y_q);
			xb_q <= ext(item.s.sample_x);
			yb_q <= ext(item.s.sample_y);
			oc_q <= item.oc;
		end
		case (state_q)
			B_SY: begin
				e_q <= (ya_q < mny) ? mny : mxy;
			end
			B_SX: begin
				e_q <= (xa_q < mnx) ? mnx : mxx;
			end
			B_EY: begin
				e_q <= oc_q.below ? mny : mxy;
			end
			B_EX: begin
				e_q <= (xb_q < mnx) ? mnx : mxx;
			end
			B_IP, B_IW: begin
				if (state_q == B_IW && md_done) begin
					case (phase_q)
						PH_SY:   begin xa_q <= ires; ya_q <= e_q; end
						PH_SX:   begin ya_q <= ires; xa_q <= e_q; end
						PH_EY:   begin xb_q <= ires; yb_q <= e_q; end
						default: begin yb_q <= ires; xb_q <= e_q; end
					endcase
				end else if (state_q == B_IP && dn_mag == '0) begin
					case (phase_q)
						PH_SY:   ya_q <= e_q;
						PH_SX:   xa_q <= e_q;
						PH_EY:   yb_q <= e_q;
						default: xb_q <= e_q;
					endcase
				end
			end
			B_PXW: begin
				if (md_done) begin
					px_q <= to_pix(md_res, negx, cfg.x_origin);
				end
			end
			B_PYW: begin
				if (md_done) begin
					if (kind_q) begin
						ln_y_q <= to_pix(md_res, negy, cfg.y_origin);
					end else begin
						mv_x_q <= px_q;
						mv_y_q <= to_pix(md_res, negy, cfg.y_origin);
					end
				end
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

/* design/polyline_clip_to_screen.sv */
// Polyline clipper and screen mapper.
// Input channel: push/full carry one vertex per beat (sample_x, sample_y in
// signed Q16.16, first_point starts a new polyline). Results leave through
// empty/pop, one command per beat: move or line with 16-bit pixel
// coordinates, last set on the final command of a vertex. A vertex gives
// zero, one or two results.
// Configuration: cfg_we writes cfg_wdata into register cfg_addr at once
// (0..3 window edges, 4..5 origins, 6..7 scales); write only while idle.
// Work: a first vertex is only recorded as the previous vertex; an unclipped
// segment runs one multiply per pixel coordinate, and each clipped edge adds
// a multiply and a 2-bit-per-cycle divide (skipped if the segment is parallel
// to that edge). All multiplies and divides share one iterative unit, and
// the back end works on one vertex at a time.
// A 2-entry input queue lets the source push while a vertex is in work, and
// a 2-entry result queue holds finished beats; a stalled receiver only halts
// the back end once the result queue is full.
// Reset loads the default window, clears both queues, sets the previous
// vertex to (0,0) and marks the next segment start as needing a clip.
`timescale 1ns / 1ps
`default_nettype none

module polyline_clip_to_screen #(
	parameter int FRAC_BITS = plclip_pkg::FracBits
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  push,
	input  wire plclip_pkg::sample_t                   sample,
	output logic                                       full,
	input  wire logic                                  pop,
	output plclip_pkg::result_t                        result,
	output logic                                       empty,
	input  wire logic                                  cfg_we,
	input  wire logic [plclip_pkg::CfgAddrWidth-1:0]   cfg_addr,
	input  wire logic [plclip_pkg::CfgDataWidth-1:0]   cfg_wdata
);
	import plclip_pkg::*;

	cfg_t    cfg_q;
	item_t   item;
	logic    item_valid, item_pop;
	logic    out_push, out_full;
	result_t out_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_x    <= -32'sd65536;
			cfg_q.max_x    <= 32'sd65536;
			cfg_q.min_y    <= -32'sd65536;
			cfg_q.max_y    <= 32'sd65536;
			cfg_q.x_origin <= '0;
			cfg_q.y_origin <= '0;
			cfg_q.x_scale  <= 31'd65536;
			cfg_q.y_scale  <= 31'd65536;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				RegMinX:    cfg_q.min_x    <= cfg_wdata[CoordWidth-1:0];
				RegMaxX:    cfg_q.max_x    <= cfg_wdata[CoordWidth-1:0];
				RegMinY:    cfg_q.min_y    <= cfg_wdata[CoordWidth-1:0];
				RegMaxY:    cfg_q.max_y    <= cfg_wdata[CoordWidth-1:0];
				RegXOrigin: cfg_q.x_origin <= cfg_wdata[OrgWidth-1:0];
				RegYOrigin: cfg_q.y_origin <= cfg_wdata[OrgWidth-1:0];
				RegXScale:  cfg_q.x_scale  <= cfg_wdata[ScaleWidth-1:0];
				RegYScale:  cfg_q.y_scale  <= cfg_wdata[ScaleWidth-1:0];
				default: begin
				end
			endcase
		end
	end

	plclip_front u_front (
		.clk   (clk),
		.arst_n(arst_n),
		.cfg   (cfg_q),
		.push  (push),
		.sample(sample),
		.full  (full),
		.pop   (item_pop),
		.item  (item),
		.valid (item_valid)
	);

	plclip_back #(
		.FRAC_BITS(FRAC_BITS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.item    (item),
		.in_valid(item_valid),
		.in_pop  (item_pop),
		.out_push(out_push),
		.out_item(out_item),
		.out_full(out_full)
	);

	plclip_fifo #(
		.WIDTH($bits(result_t)),
		.DEPTH(OutQueueDepth)
	) u_out_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (out_push),
		.wr_data(out_item),
		.full   (out_full),
		.rd_en  (pop),
		.rd_data(result),
		.empty  (empty)
	);

endmodule

`default_nettype wire

/* design/plclip_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module plclip_checker (
	input wire logic                                clk,
	input wire logic                                arst_n,
	input wire logic                                full,
	input wire logic                                pop,
	input wire plclip_pkg::result_t                 result,
	input wire logic                                empty
);
	import plclip_pkg::*;

	a_reset_queues: assert property (@(posedge clk)
		!arst_n |-> empty && !full)
		else $error("queues not empty in reset");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(result))
		else $error("waiting result changed");

	a_line_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && result.command == CmdLine |-> result.last)
		else $error("line beat without last");

	a_move_then_line: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && pop && result.command == CmdMove && !result.last
		|=> empty || result.command == CmdLine)
		else $error("open move not followed by line");

endmodule

bind polyline_clip_to_screen plclip_checker u_checker (.*);

`default_nettype wire
